### sv/car_pkg.sv
`timescale 1ns / 1ps
package car_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   // quotient bits 32..0, anything at or above 2^33 is flagged as overflow
   localparam int QBITS    = 33;
   localparam int SQ_STEPS = 32;
   localparam int NCELL    = (CORDIC_STEPS > QBITS) ? CORDIC_STEPS : QBITS;
   localparam int IDXW     = $clog2(NCELL);

   localparam int RW       = 64 + QBITS;
   localparam int CW       = 44;
   localparam int ZW       = 42;
   localparam int NBW      = 41;
   localparam int NORM_TOP = 40;
   localparam int ATAN_N   = 32;
   localparam int ATAN_W   = 40;

   localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499215;
   localparam logic [31:0] DEG90           = 32'(90 * (2 ** FRAC_BITS));

   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_SUB   = 3'd1;
   localparam logic [2:0] CMD_MULT  = 3'd2;
   localparam logic [2:0] CMD_DIV   = 3'd3;
   localparam logic [2:0] CMD_CONJ  = 3'd4;
   localparam logic [2:0] CMD_MAG   = 3'd5;
   localparam logic [2:0] CMD_PHASE = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_UNDEF = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
   } car_op_type;

   typedef struct packed {
      car_op_type         op;
      logic signed [63:0] m0;
      logic signed [63:0] m1;
      logic signed [63:0] m2;
      logic signed [63:0] m3;
      logic signed [63:0] m4;
      logic signed [63:0] m5;
   } car_prod_type;

   typedef struct packed {
      logic [2:0]           cmd;
      logic                 fin;
      logic [1:0]           st;
      logic [31:0]          rr;
      logic [31:0]          ri;
      logic                 neg0;
      logic                 neg1;
      logic                 ovf0;
      logic                 ovf1;
      logic [RW-1:0]        rem0;
      logic [RW-1:0]        rem1;
      logic [63:0]          den;
      logic [QBITS-1:0]     q0;
      logic [QBITS-1:0]     q1;
      logic [63:0]          sn;
      logic [63:0]          sres;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] cz;
      logic [NBW-1:0]       nbig;
   } car_item_type;

   typedef logic [ATAN_N-1:0][ATAN_W-1:0] atan_tab_type;

   function automatic logic [32:0] sat_to32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
      else if (v < -66'sd2147483648) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, v[31:0]};
      return r;
   endfunction

   function automatic logic [32:0] mag_to32(input logic neg, input logic [63:0] m);
      logic [32:0] r;
      logic [63:0] nm;
      nm = -m;
      if (neg) begin
         if (m > 64'd2147483648) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, nm[31:0]};
      end else begin
         if (m > 64'd2147483647) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, m[31:0]};
      end
      return r;
   endfunction

   // one term of the arctangent series, odd divisors by term number
   function automatic logic [63:0] atan_term(input logic [63:0] v, input int n);
      logic [63:0] t;
      unique case (n)
         0:  t = v;
         1:  t = v / 3;
         2:  t = v / 5;
         3:  t = v / 7;
         4:  t = v / 9;
         5:  t = v / 11;
         6:  t = v / 13;
         7:  t = v / 15;
         8:  t = v / 17;
         9:  t = v / 19;
         10: t = v / 21;
         11: t = v / 23;
         12: t = v / 25;
         13: t = v / 27;
         14: t = v / 29;
         15: t = v / 31;
         16: t = v / 33;
         17: t = v / 35;
         18: t = v / 37;
         19: t = v / 39;
         20: t = v / 41;
         21: t = v / 43;
         22: t = v / 45;
         23: t = v / 47;
         default: t = '0;
      endcase
      return t;
   endfunction

   // atan(2^-i) in Q32 degrees
   function automatic atan_tab_type build_atan();
      atan_tab_type      tab;
      logic signed [63:0] acc;
      int                sh;
      logic              done;
      for (int i = 0; i < ATAN_N; i++) begin
         acc  = '0;
         done = 1'b0;
         if (i == 0) begin
            acc = 64'sd45 <<< 32;
         end else begin
            for (int n = 0; n < 40; n++) begin
               sh = i * (2 * n + 1);
               if (sh >= 48) done = 1'b1;
               if (!done) begin
                  if ((n & 1) == 1) acc = acc - $signed(atan_term(DEG_PER_RAD_Q32 >> sh, n));
                  else acc = acc + $signed(atan_term(DEG_PER_RAD_Q32 >> sh, n));
               end
            end
         end
         tab[i] = acc[ATAN_W-1:0];
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

endpackage

### sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// stages from item accept to result valid: 5 front stages, 33 cells, 1 output
// throughput: one item per cycle, every command, while the result side does not stall the row
// each stage moves when the next one is empty or moving, so bubbles close up under stall
// reset clears the valid bits of all stages; data registers are not reset
module complex_arithmetic_unit import car_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_real,
   output logic signed [31:0] rsp_result_imag,
   output logic [1:0]         rsp_status
);

   // chain links: index 0 feeds the first cell, index NCELL leaves the last
   logic [NCELL:0] lnk_valid;
   logic [NCELL:0] lnk_ready;
   car_item_type   lnk_item [NCELL+1];

   // operand register, products, sums and direct results, divide check and normalization
   car_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_command (req_command),
      .in_a_real  (req_a_real),
      .in_a_imag  (req_a_imag),
      .in_b_real  (req_b_real),
      .in_b_imag  (req_b_imag),
      .out_valid  (lnk_valid[0]),
      .out_ready  (lnk_ready[0]),
      .out_item   (lnk_item[0])
   );

   // row of identical cells: each does one quotient bit for both divide lanes, and cells below
   // 32 also one square root bit, cells below 16 also one rotation of the phase search
   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      car_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .idx       (IDXW'(g)),
         .in_valid  (lnk_valid[g]),
         .in_ready  (lnk_ready[g]),
         .in_item   (lnk_item[g]),
         .out_valid (lnk_valid[g+1]),
         .out_ready (lnk_ready[g+1]),
         .out_item  (lnk_item[g+1])
      );
   end

   // result selection, clamping and the output register
   car_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (lnk_valid[NCELL]),
      .in_ready        (lnk_ready[NCELL]),
      .in_item         (lnk_item[NCELL]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_real (rsp_result_real),
      .rsp_result_imag (rsp_result_imag),
      .rsp_status      (rsp_status)
   );

endmodule

### sv/car_front.sv
`timescale 1ns / 1ps
module car_front import car_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [2:0]         in_command,
   input  logic signed [31:0] in_a_real,
   input  logic signed [31:0] in_a_imag,
   input  logic signed [31:0] in_b_real,
   input  logic signed [31:0] in_b_imag,
   output logic               out_valid,
   input  logic               out_ready,
   output car_item_type       out_item
);

   logic         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic         rdy1, rdy2, rdy3, rdy4, rdy5;
   car_op_type   op1_ff, op1_in;
   car_prod_type pr2_ff, pr2_in;
   car_item_type it3_ff, it3_in, it4_ff, it4_in, it5_ff, it5_in;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign out_valid = v5_ff;
   assign out_item  = it5_ff;

   always_comb begin
      op1_in.cmd = in_command;
      op1_in.ar  = in_a_real;
      op1_in.ai  = in_a_imag;
      op1_in.br  = in_b_real;
      op1_in.bi  = in_b_imag;
   end

   // products; the square pair serves the divisor or the magnitude
   always_comb begin
      pr2_in.op = op1_ff;
      pr2_in.m0 = op1_ff.ar * op1_ff.br;
      pr2_in.m1 = op1_ff.ai * op1_ff.bi;
      pr2_in.m2 = op1_ff.ar * op1_ff.bi;
      pr2_in.m3 = op1_ff.ai * op1_ff.br;
      if (op1_ff.cmd == CMD_MAG) begin
         pr2_in.m4 = op1_ff.ar * op1_ff.ar;
         pr2_in.m5 = op1_ff.ai * op1_ff.ai;
      end else begin
         pr2_in.m4 = op1_ff.br * op1_ff.br;
         pr2_in.m5 = op1_ff.bi * op1_ff.bi;
      end
   end

   // sums, direct results and setup for the cell row
   always_comb begin
      car_op_type           o;
      logic signed [65:0]   dre, dim, mre, mim;
      logic [63:0]          den;
      logic [32:0]          ra, rb;
      logic signed [CW-1:0] xs, ys, ay, big;
      o   = pr2_ff.op;
      dre = 66'(pr2_ff.m0) + 66'(pr2_ff.m1);
      dim = 66'(pr2_ff.m3) - 66'(pr2_ff.m2);
      mre = 66'(pr2_ff.m0) - 66'(pr2_ff.m1);
      mim = 66'(pr2_ff.m2) + 66'(pr2_ff.m3);
      den = 64'(pr2_ff.m4 + pr2_ff.m5);
      xs  = o.ar[31] ? -CW'(o.ar) : CW'(o.ar);
      ys  = o.ar[31] ? -CW'(o.ai) : CW'(o.ai);
      ay  = ys[CW-1] ? -ys : ys;
      big = (xs > ay) ? xs : ay;
      ra  = '0;
      rb  = '0;

      it3_in      = '0;
      it3_in.cmd  = o.cmd;
      it3_in.den  = den;
      it3_in.sn   = den;
      it3_in.neg0 = dre[65];
      it3_in.neg1 = dim[65];
      it3_in.rem0 = RW'(dre[65] ? 64'(-dre) : dre[63:0]);
      it3_in.rem1 = RW'(dim[65] ? 64'(-dim) : dim[63:0]);
      it3_in.cx   = xs;
      it3_in.cy   = ys;
      it3_in.nbig = NBW'(big);
      it3_in.fin  = 1'b1;
      it3_in.st   = ST_OK;

      unique case (o.cmd)
         CMD_ADD: begin
            ra = sat_to32(66'(o.ar) + 66'(o.br));
            rb = sat_to32(66'(o.ai) + 66'(o.bi));
         end
         CMD_SUB: begin
            ra = sat_to32(66'(o.ar) - 66'(o.br));
            rb = sat_to32(66'(o.ai) - 66'(o.bi));
         end
         CMD_MULT: begin
            ra = sat_to32(mre >>> FRAC_BITS);
            rb = sat_to32(mim >>> FRAC_BITS);
         end
         CMD_DIV: begin
            if (den == '0) it3_in.st = ST_DIV0;
            else it3_in.fin = 1'b0;
         end
         CMD_CONJ: begin
            ra = {1'b0, o.ar};
            rb = sat_to32(-66'(o.ai));
         end
         CMD_MAG: begin
            it3_in.fin = 1'b0;
         end
         CMD_PHASE: begin
            if (o.ar != '0) it3_in.fin = 1'b0;
            else if (o.ai > 0) ra = {1'b0, DEG90};
            else if (o.ai < 0) ra = {1'b0, 32'(-DEG90)};
            else it3_in.st = ST_UNDEF;
         end
         default: begin
            ra = '0;
         end
      endcase
      it3_in.rr = ra[31:0];
      it3_in.ri = rb[31:0];
      if ((ra[32] || rb[32]) && it3_in.st == ST_OK) it3_in.st = ST_SAT;
   end

   // divide overflow check and first half of the phase normalization
   always_comb begin
      logic [RW-1:0]    lim;
      logic [NBW+31:0]  bw;
      int               k;
      it4_in      = it3_ff;
      it4_in.rem0 = it3_ff.rem0 << FRAC_BITS;
      it4_in.rem1 = it3_ff.rem1 << FRAC_BITS;
      lim         = RW'(it3_ff.den) << QBITS;
      it4_in.ovf0 = it4_in.rem0 >= lim;
      it4_in.ovf1 = it4_in.rem1 >= lim;
      for (int j = 0; j < 3; j++) begin
         k  = 32 >> j;
         bw = (NBW+32)'(it4_in.nbig) << k;
         if (bw < ((NBW+32)'(1) << NORM_TOP)) begin
            it4_in.nbig = it4_in.nbig << k;
            it4_in.cx   = it4_in.cx <<< k;
            it4_in.cy   = it4_in.cy <<< k;
         end
      end
   end

   // rest of the normalization, largest value ends in [2^40, 2^41)
   always_comb begin
      logic [NBW+31:0] bw;
      int              k;
      it5_in = it4_ff;
      for (int j = 3; j < 6; j++) begin
         k  = 32 >> j;
         bw = (NBW+32)'(it5_in.nbig) << k;
         if (bw < ((NBW+32)'(1) << NORM_TOP)) begin
            it5_in.nbig = it5_in.nbig << k;
            it5_in.cx   = it5_in.cx <<< k;
            it5_in.cy   = it5_in.cy <<< k;
         end
      end
      it5_in.nbig = it5_in.nbig << 1;
      it5_in.cx   = it5_in.cx <<< 1;
      it5_in.cy   = it5_in.cy <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) op1_ff <= op1_in;
      if (rdy2) pr2_ff <= pr2_in;
      if (rdy3) it3_ff <= it3_in;
      if (rdy4) it4_ff <= it4_in;
      if (rdy5) it5_ff <= it5_in;
   end

endmodule

### sv/car_cell.sv
`timescale 1ns / 1ps
module car_cell import car_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [IDXW-1:0] idx,
   input  logic            in_valid,
   output logic            in_ready,
   input  car_item_type    in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output car_item_type    out_item
);

   logic         valid_ff;
   car_item_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      logic [IDXW-1:0]      ks;
      logic [RW-1:0]        dsh;
      logic [6:0]           sa;
      logic [63:0]          bitv, t;
      logic signed [CW-1:0] sx, sy;
      logic signed [ZW-1:0] av;
      item_in = in_item;

      // one quotient bit per lane, weight 2^(32-idx)
      ks  = IDXW'(QBITS - 1) - idx;
      dsh = RW'(in_item.den) << ks;
      if (in_item.rem0 >= dsh) begin
         item_in.rem0 = in_item.rem0 - dsh;
         item_in.q0   = {in_item.q0[QBITS-2:0], 1'b1};
      end else begin
         item_in.q0   = {in_item.q0[QBITS-2:0], 1'b0};
      end
      if (in_item.rem1 >= dsh) begin
         item_in.rem1 = in_item.rem1 - dsh;
         item_in.q1   = {in_item.q1[QBITS-2:0], 1'b1};
      end else begin
         item_in.q1   = {in_item.q1[QBITS-2:0], 1'b0};
      end

      // one root bit, test value 4^(31-idx)
      sa   = 7'd62 - {idx, 1'b0};
      bitv = 64'd1 << sa;
      t    = in_item.sres + bitv;
      if (idx < IDXW'(SQ_STEPS)) begin
         if (in_item.sn >= t) begin
            item_in.sn   = in_item.sn - t;
            item_in.sres = (in_item.sres >> 1) + bitv;
         end else begin
            item_in.sres = in_item.sres >> 1;
         end
      end

      // one vectoring rotation
      sx = in_item.cx >>> idx;
      sy = in_item.cy >>> idx;
      av = $signed(ZW'(ATAN_TAB[idx[4:0]]));
      if (idx < IDXW'(CORDIC_STEPS)) begin
         if (!in_item.cy[CW-1]) begin
            item_in.cx = in_item.cx + sy;
            item_in.cy = in_item.cy - sx;
            item_in.cz = in_item.cz + av;
         end else begin
            item_in.cx = in_item.cx - sy;
            item_in.cy = in_item.cy + sx;
            item_in.cz = in_item.cz - av;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) item_ff <= item_in;
   end

endmodule

### sv/car_back.sv
`timescale 1ns / 1ps
module car_back import car_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  car_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_result_real,
   output logic [31:0]  rsp_result_imag,
   output logic [1:0]   rsp_status
);

   logic        valid_ff;
   logic [31:0] rr_ff, ri_ff, rr_in, ri_in;
   logic [1:0]  st_ff, st_in;

   assign in_ready        = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_result_real = rr_ff;
   assign rsp_result_imag = ri_ff;
   assign rsp_status      = st_ff;

   always_comb begin
      logic [32:0]          ra, rb;
      logic signed [ZW-1:0] zr;
      ra    = {1'b0, in_item.rr};
      rb    = {1'b0, in_item.ri};
      st_in = in_item.st;
      zr    = (in_item.cz + $signed(ZW'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
      if (!in_item.fin) begin
         unique case (in_item.cmd)
            CMD_DIV: begin
               ra = mag_to32(in_item.neg0, in_item.ovf0 ? '1 : 64'(in_item.q0));
               rb = mag_to32(in_item.neg1, in_item.ovf1 ? '1 : 64'(in_item.q1));
            end
            CMD_MAG: begin
               ra = mag_to32(1'b0, in_item.sres);
               rb = '0;
            end
            CMD_PHASE: begin
               ra = {1'b0, zr[31:0]};
               rb = '0;
            end
            default: begin
               rb = '0;
            end
         endcase
         st_in = (ra[32] || rb[32]) ? ST_SAT : ST_OK;
      end
      rr_in = ra[31:0];
      ri_in = rb[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rr_ff <= rr_in;
         ri_ff <= ri_in;
         st_ff <= st_in;
      end
   end

endmodule

### tb/complex_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_checker import car_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_result_real,
   input  logic signed [31:0] rsp_result_imag,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [1:0]         st;
   } cplx_result_type;

   cplx_result_type answers_q[$];

   function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                  inout logic sat);
      if (v > 66'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -66'sd2147483648) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] signed_of(input logic neg, input logic [63:0] m,
                                                    inout logic sat);
      logic signed [65:0] v;
      v = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
      return clamp32(v, sat);
   endfunction

   function automatic logic [63:0] split_sum(input logic signed [63:0] p,
                                             input logic signed [63:0] q, output logic neg);
      logic signed [65:0] s;
      s = 66'(p) + 66'(q);
      neg = s < 0;
      return neg ? 64'(-s) : 64'(s);
   endfunction

   function automatic logic signed [31:0] prod_term(input logic signed [63:0] p,
                                                    input logic signed [63:0] q,
                                                    inout logic sat);
      logic        neg;
      logic [63:0] m;
      m = split_sum(p, q, neg);
      m = neg ? (m + 64'hFFFF) >> FRAC_BITS : m >> FRAC_BITS;
      return signed_of(neg, m, sat);
   endfunction

   function automatic logic signed [31:0] quot_term(input logic signed [63:0] p,
                                                    input logic signed [63:0] q,
                                                    input logic [63:0] den, inout logic sat);
      logic        neg;
      logic [63:0] m, quo, rem;
      m   = split_sum(p, q, neg);
      quo = m / den;
      rem = m % den;
      if (quo > 64'h1_0000_0000) quo = 64'h1_0000_0000;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
         if (quo > 64'h1_0000_0000) quo = 64'h1_0000_0000;
      end
      return signed_of(neg, quo, sat);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] res, bits;
      res  = '0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= res + bits) begin
            n   = n - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // atan(2^-i) in q32 degrees by the alternating series
   function automatic logic signed [63:0] atan_q32(input int i);
      logic signed [63:0] acc, deg;
      int sh;
      deg = 64'sd246083499215;
      acc = '0;
      if (i == 0) return 64'sd45 <<< 32;
      for (int n = 0; n < 40; n++) begin
         sh = i * (2 * n + 1);
         if (sh >= 48) break;
         if (n % 2 == 1) acc = acc - (deg >>> sh) / (2 * n + 1);
         else acc = acc + (deg >>> sh) / (2 * n + 1);
      end
      return acc;
   endfunction

   function automatic logic signed [63:0] cordic_angle(input logic signed [63:0] x,
                                                       input logic signed [63:0] y);
      logic signed [63:0] z, nx, big, ay;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
      end
      ay  = (y < 0) ? -y : y;
      big = (x > ay) ? x : ay;
      while (big < (64'sd1 <<< 40)) begin
         x = x * 2;
         y = y * 2;
         big = big * 2;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_q32(i);
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_q32(i);
         end
         x = nx;
      end
      return (z + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   endfunction

   function automatic cplx_result_type compute_result(input logic [2:0] cmd,
                                                      input logic signed [31:0] ar,
                                                      input logic signed [31:0] ai,
                                                      input logic signed [31:0] br,
                                                      input logic signed [31:0] bi);
      cplx_result_type    r;
      logic               sat;
      logic signed [63:0] xr, xi, yr, yi;
      logic [63:0]        den, mag;
      sat  = 1'b0;
      r.re = '0;
      r.im = '0;
      r.st = ST_OK;
      xr = ar; xi = ai; yr = br; yi = bi;
      case (cmd)
         CMD_ADD: begin
            r.re = clamp32(66'(xr) + 66'(yr), sat);
            r.im = clamp32(66'(xi) + 66'(yi), sat);
         end
         CMD_SUB: begin
            r.re = clamp32(66'(xr) - 66'(yr), sat);
            r.im = clamp32(66'(xi) - 66'(yi), sat);
         end
         CMD_MULT: begin
            r.re = prod_term(xr * yr, -(xi * yi), sat);
            r.im = prod_term(xr * yi, xi * yr, sat);
         end
         CMD_DIV: begin
            den = 64'(yr * yr) + 64'(yi * yi);
            if (den == 0) r.st = ST_DIV0;
            else begin
               r.re = quot_term(xr * yr, xi * yi, den, sat);
               r.im = quot_term(xi * yr, -(xr * yi), den, sat);
            end
         end
         CMD_CONJ: begin
            r.re = ar;
            r.im = clamp32(-66'(xi), sat);
         end
         CMD_MAG: begin
            mag  = floor_sqrt(64'(xr * xr) + 64'(xi * xi));
            r.re = signed_of(1'b0, mag, sat);
         end
         CMD_PHASE: begin
            if (ar == 0) begin
               if (ai > 0) r.re = DEG90;
               else if (ai < 0) r.re = -$signed(DEG90);
               else r.st = ST_UNDEF;
            end else begin
               r.re = clamp32(66'(cordic_angle(xr, xi)), sat);
            end
         end
         default: ;
      endcase
      if (sat && r.st == ST_OK) r.st = ST_SAT;
      return r;
   endfunction

   assign pending = answers_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answers_q.size() == 0) begin
               $display("%0t: result with nothing outstanding: %h %h %h", $realtime,
                        rsp_result_real, rsp_result_imag, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_q.pop_front();
               if (want.re !== rsp_result_real || want.im !== rsp_result_imag ||
                   want.st !== rsp_status) begin
                  $display("%0t: mismatch expected re %h im %h st %0d, actual re %h im %h st %0d",
                           $realtime, want.re, want.im, want.st,
                           rsp_result_real, rsp_result_imag, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            answers_q.push_back(compute_result(req_command, req_a_real, req_a_imag,
                                               req_b_real, req_b_imag));
      end
   end

endmodule

### tb/complex_arithmetic_unit_test.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_test;
   import car_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_command;
   logic signed [31:0] req_a_real;
   logic signed [31:0] req_a_imag;
   logic signed [31:0] req_b_real;
   logic signed [31:0] req_b_imag;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_result_real;
   logic signed [31:0] rsp_result_imag;
   logic [1:0]         rsp_status;
   int                 fail_count;
   int                 pending;
   logic               hold_off;   // long receiver stall requested by the sender
   logic               quiet;      // stretch with no idling on either side

   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;

   complex_arithmetic_unit u_top (.*);

   complex_arithmetic_unit_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5ms;
      $display("complex_arithmetic_unit verification failed");
      $finish;
   end

   // operand with a mix of full range, small values and the extremes
   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3, 4, 5: return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
         6: return $signed(32'($urandom_range(0, 255))) - 32'sd128;
         default: return $signed($urandom());
      endcase
   endfunction

   // present one item and wait for its accept edge
   task automatic offer_item(input logic [2:0] cmd, input logic signed [31:0] ar,
                             input logic signed [31:0] ai, input logic signed [31:0] br,
                             input logic signed [31:0] bi);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_a_real  <= ar;
      req_a_imag  <= ai;
      req_b_real  <= br;
      req_b_imag  <= bi;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random ready gaps, plus one long hold-off
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int wait_cycles;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_ADD;
      req_a_real   <= '0;
      req_a_imag   <= '0;
      req_b_real   <= '0;
      req_b_imag   <= '0;
      hold_off     = 1'b0;
      quiet        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every command, the special cases
      offer_item(CMD_ADD, MAXV, MINV, MAXV, MINV);          // saturate both ways
      offer_item(CMD_ADD, ONE, -ONE, 32'sd3, 32'sd5);
      offer_item(CMD_SUB, MINV, MAXV, MAXV, MINV);
      offer_item(CMD_SUB, 32'sd100, 32'sd7, 32'sd100, -32'sd7);
      offer_item(CMD_MULT, MINV, MINV, MINV, MINV);
      offer_item(CMD_MULT, -32'sd1, 32'sd1, 32'sd1, 32'sd1);  // floor of tiny negative
      offer_item(CMD_MULT, 2 * ONE, 3 * ONE, -ONE, ONE);
      offer_item(CMD_DIV, ONE, ONE, '0, '0);                 // divide by zero
      offer_item(CMD_DIV, MAXV, MINV, 32'sd1, '0);           // quotient overflow
      offer_item(CMD_DIV, 5 * ONE, -ONE, 2 * ONE, ONE);
      offer_item(CMD_DIV, MINV, MINV, MINV, MINV);
      offer_item(CMD_DIV, -32'sd7, 32'sd3, MAXV, MAXV);
      offer_item(CMD_CONJ, MAXV, MINV, '0, '0);               // negating the minimum
      offer_item(CMD_CONJ, MINV, MAXV, MAXV, MAXV);
      offer_item(CMD_MAG, MINV, MINV, '0, '0);
      offer_item(CMD_MAG, 3 * ONE, 4 * ONE, '0, '0);
      offer_item(CMD_PHASE, '0, '0, '0, '0);                  // origin
      offer_item(CMD_PHASE, '0, 32'sd1, '0, '0);              // positive imaginary axis
      offer_item(CMD_PHASE, '0, MINV, '0, '0);                // negative imaginary axis
      offer_item(CMD_PHASE, -ONE, ONE, '0, '0);               // left half plane
      offer_item(CMD_PHASE, MAXV, MINV, '0, '0);
      offer_item(CMD_PHASE, 32'sd1, MAXV, '0, '0);
      offer_item(3'd7, MAXV, MAXV, MAXV, MAXV);               // unused command

      // random items, with a long result stall and stretches without idling
      for (int n = 0; n < 650; n++) begin
         if (n == 200) hold_off = 1'b1;
         if (n % 100 == 50) quiet = 1'b1;
         if (n % 100 == 80) quiet = 1'b0;
         offer_item(($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                    pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      req_valid    <= 1'b0;

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("complex_arithmetic_unit verification clean");
      end else begin
         $display("complex_arithmetic_unit verification failed");
      end
      $finish;
   end

endmodule
